>>> hdl/tbe_pkg.sv
// Shared types, constants and the round mixing function of the reduced TEA
// encryption block. Used by every module of the block; depends on nothing.
`default_nettype none

package tbe_pkg;

  // Round structure
  localparam int unsigned MaxCycles = 32;
  localparam int unsigned CycW      = $clog2(MaxCycles);
  localparam int unsigned RoundCntW = 7;
  localparam int unsigned ShiftLeft  = 4;
  localparam int unsigned ShiftRight = 5;

  // Register reset values
  localparam logic [RoundCntW-1:0] RoundCountReset = RoundCntW'(2 * MaxCycles);
  localparam logic [31:0]          DeltaReset      = 32'h9E37_79B9;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgKey0       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKey1       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKey2       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKey3       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRoundCount = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDelta      = 3'd5;

  // Input item: one plaintext block
  typedef struct packed {
    logic [31:0] left_in;
    logic [31:0] right_in;
  } tbe_in_t;

  // Result item: one ciphertext block
  typedef struct packed {
    logic [31:0] left_out;
    logic [31:0] right_out;
  } tbe_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic skip_right;
    logic out_load;
  } tbe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CycW-1:0] cycles_m1;
    logic            odd;
  } tbe_stat_t;

  // F(x, a, b) = ((x << 4) + a) ^ (x + sum) ^ ((x >> 5) + b)
  function automatic logic [31:0] mix_word(input logic [31:0] x,
                                           input logic [31:0] sum,
                                           input logic [31:0] ka,
                                           input logic [31:0] kb);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = (x << ShiftLeft) + ka;
    b = x + sum;
    c = (x >> ShiftRight) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tbe_datapath.sv
// Datapath of the reduced TEA block: configuration registers, the working
// words and running sum, one full Feistel cycle per clock, output register.
// Depends on tbe_pkg.
`default_nettype none

module tbe_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tbe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire tbe_pkg::tbe_in_t            in_data_i,
  input  wire tbe_pkg::tbe_cmd_t           cmd_i,
  output tbe_pkg::tbe_stat_t               stat_o,
  output tbe_pkg::tbe_out_t                out_data_o
);

  logic [31:0] key0_q, key1_q, key2_q, key3_q, delta_q;
  logic [tbe_pkg::RoundCntW-1:0] round_count_q;

  logic [31:0] left_q, left_d;
  logic [31:0] right_q, right_d;
  logic [31:0] sum_q, sum_d;
  tbe_pkg::tbe_out_t out_q;

  logic [tbe_pkg::RoundCntW-1:0] halves;

  localparam logic [tbe_pkg::RoundCntW-1:0] HalfMax =
    tbe_pkg::RoundCntW'(2 * tbe_pkg::MaxCycles);
  localparam logic [tbe_pkg::RoundCntW-1:0] HalfMin = tbe_pkg::RoundCntW'(1);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q        <= '0;
      key1_q        <= '0;
      key2_q        <= '0;
      key3_q        <= '0;
      round_count_q <= tbe_pkg::RoundCountReset;
      delta_q       <= tbe_pkg::DeltaReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tbe_pkg::CfgKey0:       key0_q        <= cfg_data_i;
        tbe_pkg::CfgKey1:       key1_q        <= cfg_data_i;
        tbe_pkg::CfgKey2:       key2_q        <= cfg_data_i;
        tbe_pkg::CfgKey3:       key3_q        <= cfg_data_i;
        tbe_pkg::CfgRoundCount: round_count_q <= cfg_data_i[tbe_pkg::RoundCntW-1:0];
        tbe_pkg::CfgDelta:      delta_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the half-round count into its legal range, derive cycle count
  always_comb begin
    halves = round_count_q;
    if (round_count_q == '0) begin
      halves = HalfMin;
    end else if (round_count_q > HalfMax) begin
      halves = HalfMax;
    end
  end

  assign stat_o.cycles_m1 = tbe_pkg::CycW'((halves - HalfMin) >> 1);
  assign stat_o.odd       = halves[0];

  // One full cycle: advance sum, update left, then right from the new left
  always_comb begin
    sum_d   = sum_q + delta_q;
    left_d  = left_q + tbe_pkg::mix_word(right_q, sum_d, key0_q, key1_q);
    right_d = right_q + tbe_pkg::mix_word(left_d, sum_d, key2_q, key3_q);
  end

  // Load a new block or advance the working words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q  <= in_data_i.left_in;
      right_q <= in_data_i.right_in;
      sum_q   <= '0;
    end else if (cmd_i.step) begin
      sum_q  <= sum_d;
      left_q <= left_d;
      if (!cmd_i.skip_right) begin
        right_q <= right_d;
      end
    end
  end

  // Capture the finished block into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.left_out  <= left_q;
      out_q.right_out <= right_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> hdl/tbe_ctrl.sv
// Controller of the reduced TEA block: accepts an item, counts round cycles
// and hands the result to the output register. Depends on tbe_pkg.
`default_nettype none

module tbe_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire tbe_pkg::tbe_stat_t stat_i,
  output tbe_pkg::tbe_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [tbe_pkg::CycW-1:0] cnt_q;
  logic                  odd_q;
  logic                  out_valid_q;
  logic                  last_cycle;
  logic                  out_free;

  assign last_cycle = (cnt_q == '0);
  assign out_free   = !out_valid_q || out_ready_i;

  // Decode commands from the current state
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step       = (state_q == ST_RUN);
    cmd_o.skip_right = (state_q == ST_RUN) && last_cycle && odd_q;
    cmd_o.out_load   = (state_q == ST_DONE) && out_free;
  end

  // Hold state, round counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= stat_i.cycles_m1;
            odd_q   <= stat_i.odd;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_cycle) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/tea_block_encrypt_reduced.sv
// Reduced-round TEA encryption, top level: joins controller and datapath.
// Depends on tbe_pkg, tbe_ctrl and tbe_datapath.
//
// Encrypts one 64-bit block per item under a 128-bit key with a configurable
// number of half-rounds (1..64; zero counts as 1, larger values as 64). The
// datapath performs one full TEA cycle (two chained half-rounds) per clock in
// the round loop. An item is accepted in the idle state, then runs the round
// loop, then its result moves into the output register; a new item is taken
// only after that move, which waits while a previous result is still unread.
// The output register lets the next item start while the previous result
// still waits on the output side. Configuration writes are always accepted
// and must only be issued while the block is idle.
`default_nettype none

module tea_block_encrypt_reduced (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tbe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire tbe_pkg::tbe_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tbe_pkg::tbe_out_t                out_data_o
);

  tbe_pkg::tbe_cmd_t  cmd;
  tbe_pkg::tbe_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbe_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> hdl/tbe_checker.sv
// Port-level checks for the reduced TEA block and their bind to the top
// level. Depends on tbe_pkg and tea_block_encrypt_reduced.
`default_nettype none

module tbe_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        cfg_valid_i,
  input wire logic                        cfg_ready_o,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire tbe_pkg::tbe_out_t           out_data_o
);

  // Stalled result item holds valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed or dropped");

  // Block is busy in the cycle after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // No result appears in the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result item appeared too early");

  // Configuration port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind tea_block_encrypt_reduced tbe_checker u_tbe_checker (.*);

`default_nettype wire

>>> test/tb_tea_block_encrypt_reduced.sv
// Testbench for tea_block_encrypt_reduced: predicts each ciphertext block from a local
// copy of the key, round count and delta, and checks every result under random idling.
// Depends on tbe_pkg and the tea_block_encrypt_reduced RTL.
`default_nettype none

module tb_tea_block_encrypt_reduced;

  // Indexes past the last register; writes to them must be ignored
  localparam logic [tbe_pkg::CfgIdxW-1:0] CfgUnused6 = 3'd6;
  localparam logic [tbe_pkg::CfgIdxW-1:0] CfgUnused7 = 3'd7;
  localparam int unsigned        MaxHalves  = 2 * tbe_pkg::MaxCycles;
  localparam int                 HoldCycles = 400;
  localparam int                 SetItems   = 50;

  logic                        clk;
  logic                        rst_n       = 1'b0;
  logic                        cfg_valid   = 1'b0;
  logic [tbe_pkg::CfgIdxW-1:0] cfg_index   = '0;
  logic [31:0]                 cfg_data    = '0;
  logic                        in_valid    = 1'b0;
  tbe_pkg::tbe_in_t            in_data     = '0;
  logic                        out_ready   = 1'b0;
  logic                        cfg_ready_o;
  logic                        in_ready_o;
  logic                        out_valid_o;
  tbe_pkg::tbe_out_t           out_data_o;

  // Local copy of the configuration registers
  logic [31:0]                   key_q [4];
  logic [tbe_pkg::RoundCntW-1:0] half_rounds_q;
  logic [31:0]                   delta_q;

  tbe_pkg::tbe_out_t cipher_q [$];
  int       fail_cnt     = 0;
  int       in_idle_pct  = 0;
  int       out_idle_pct = 0;
  int       hold_req     = 0;
  int       hold_seen    = 0;
  int       hold_left    = 0;

  tea_block_encrypt_reduced i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tea_block_encrypt_reduced test failed");
    $finish;
  end

  // TEA round function on one word
  function automatic logic [31:0] feistel_f(input logic [31:0] x, input logic [31:0] sum,
                                            input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] t_shl;
    logic [31:0] t_add;
    logic [31:0] t_shr;
    t_shl = {x[27:0], 4'b0000} + ka;
    t_add = x + sum;
    t_shr = {5'b00000, x[31:5]} + kb;
    return t_shl ^ t_add ^ t_shr;
  endfunction

  // Encrypt one block with the current settings; sum restarts at zero per block
  function automatic tbe_pkg::tbe_out_t encrypt_block(input tbe_pkg::tbe_in_t blk);
    logic [31:0]       l;
    logic [31:0]       r;
    logic [31:0]       sum;
    int unsigned       halves;
    tbe_pkg::tbe_out_t res;
    l      = blk.left_in;
    r      = blk.right_in;
    sum    = '0;
    halves = half_rounds_q;
    if (halves == 0) halves = 1;
    if (halves > MaxHalves) halves = MaxHalves;
    for (int h = 0; h < halves; h++) begin
      if (h % 2 == 0) begin
        sum = sum + delta_q;
        l   = l + feistel_f(r, sum, key_q[0], key_q[1]);
      end else begin
        r = r + feistel_f(l, sum, key_q[2], key_q[3]);
      end
    end
    res.left_out  = l;
    res.right_out = r;
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t: ERROR %s", $time, msg);
    fail_cnt++;
  endtask

  // Drop input valid and wait until every expected block has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register while idle and mirror it locally
  task automatic write_reg(input logic [tbe_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      tbe_pkg::CfgKey0:       key_q[0] = data;
      tbe_pkg::CfgKey1:       key_q[1] = data;
      tbe_pkg::CfgKey2:       key_q[2] = data;
      tbe_pkg::CfgKey3:       key_q[3] = data;
      tbe_pkg::CfgRoundCount: half_rounds_q = data[tbe_pkg::RoundCntW-1:0];
      tbe_pkg::CfgDelta:      delta_q = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one block, keep valid up after acceptance for a back-to-back follower
  task automatic send_block(input tbe_pkg::tbe_in_t blk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    cipher_q.push_back(encrypt_block(blk));
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic tbe_pkg::tbe_in_t random_block();
    tbe_pkg::tbe_in_t blk;
    blk.left_in  = pick_word();
    blk.right_in = pick_word();
    return blk;
  endfunction

  task automatic write_keys(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
    write_reg(tbe_pkg::CfgKey0, k0);
    write_reg(tbe_pkg::CfgKey1, k1);
    write_reg(tbe_pkg::CfgKey2, k2);
    write_reg(tbe_pkg::CfgKey3, k3);
  endtask

  // Random settings, biased toward the round-count extremes
  task automatic random_config();
    logic [6:0] rc;
    case ($urandom_range(3))
      0:       rc = 7'd1;
      1:       rc = 7'(MaxHalves);
      default: rc = 7'($urandom_range(0, 127));
    endcase
    write_keys(pick_word(), pick_word(), pick_word(), pick_word());
    write_reg(tbe_pkg::CfgRoundCount, {25'($urandom), rc});
    write_reg(tbe_pkg::CfgDelta, ($urandom_range(3) == 0) ? tbe_pkg::DeltaReset : pick_word());
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? CfgUnused6 : CfgUnused7, $urandom);
  endtask

  // Defaults after reset: zero key, 64 half-rounds, standard delta
  task automatic test_reset_defaults();
    send_block('{32'h0000_0000, 32'h0000_0000});
    send_block('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_block('{32'h0123_4567, 32'h89AB_CDEF});
  endtask

  // Smallest and largest legal counts, odd and even
  task automatic test_round_counts();
    logic [6:0] counts [4] = '{7'd1, 7'd2, 7'd63, 7'd64};
    write_keys(32'hA56B_ABCD, 32'h0000_F0F0, 32'hFFFF_0000, 32'h1234_5678);
    foreach (counts[i]) begin
      write_reg(tbe_pkg::CfgRoundCount, {25'd0, counts[i]});
      send_block('{32'hAAAA_AAAA, 32'h5555_5555});
      send_block('{32'h5555_5555, 32'hAAAA_AAAA});
    end
  endtask

  // Zero count runs one half-round; counts past 64 clamp; upper data bits drop
  task automatic test_count_saturation();
    write_reg(tbe_pkg::CfgRoundCount, 32'd0);
    send_block('{32'h8000_0001, 32'h7FFF_FFFE});
    write_reg(tbe_pkg::CfgRoundCount, 32'd65);
    send_block('{32'h8000_0001, 32'h7FFF_FFFE});
    write_reg(tbe_pkg::CfgRoundCount, 32'd127);
    send_block('{32'hFFFF_FFFF, 32'h0000_0000});
    write_reg(tbe_pkg::CfgRoundCount, 32'hFFFF_FF80);
    send_block('{32'h0000_0000, 32'hFFFF_FFFF});
  endtask

  // Key and delta extremes, then writes to unused indexes
  task automatic test_key_extremes();
    write_reg(tbe_pkg::CfgRoundCount, 32'd64);
    write_keys('1, '1, '1, '1);
    write_reg(tbe_pkg::CfgDelta, 32'h0000_0000);
    send_block('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    write_reg(tbe_pkg::CfgDelta, 32'hFFFF_FFFF);
    send_block('{32'h0000_0000, 32'h0000_0000});
    write_reg(CfgUnused6, 32'hDEAD_BEEF);
    write_reg(CfgUnused7, 32'hFFFF_FFFF);
    send_block('{32'h1357_9BDF, 32'h2468_ACE0});
  endtask

  // Hold the output off long enough that the input stalls behind it
  task automatic test_output_stall();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_reg(tbe_pkg::CfgRoundCount, 32'd5);
    hold_req++;
    repeat (30) send_block(random_block());
    wait_idle();
  endtask

  task automatic test_random(input int in_pct, input int out_pct, input int sets);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (sets) begin
      random_config();
      repeat (SetItems) send_block(random_block());
    end
    wait_idle();
  endtask

  // Count down a requested output hold
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each accepted result, then pick the next ready
  always @(posedge clk) begin
    tbe_pkg::tbe_out_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (cipher_q.size() == 0) begin
        report_error($sformatf("unexpected result %016h", out_data_o));
      end else begin
        want = cipher_q.pop_front();
        if (out_data_o.left_out !== want.left_out)
          report_error($sformatf("left_out: expected %08h, got %08h",
                                 want.left_out, out_data_o.left_out));
        if (out_data_o.right_out !== want.right_out)
          report_error($sformatf("right_out: expected %08h, got %08h",
                                 want.right_out, out_data_o.right_out));
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    foreach (key_q[i]) key_q[i] = '0;
    half_rounds_q = tbe_pkg::RoundCountReset;
    delta_q       = tbe_pkg::DeltaReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 34;
    out_idle_pct = 65;
    test_reset_defaults();
    test_round_counts();
    test_count_saturation();
    test_key_extremes();
    test_random(34, 65, 6);
    test_random(65, 34, 6);
    test_random(0, 0, 6);
    test_output_stall();

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tea_block_encrypt_reduced test passed");
    end else begin
      $display("tea_block_encrypt_reduced test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hdl/tbe_pkg.sv
hdl/tbe_datapath.sv
hdl/tbe_ctrl.sv
hdl/tea_block_encrypt_reduced.sv
hdl/tbe_checker.sv
test/tb_tea_block_encrypt_reduced.sv
